// ===== src/nfa2d_pkg.sv =====
// ============================================================================
// nfa2d_pkg : shared types and constants
// Command codes, register indexes and the result word of the subset builder.
// ============================================================================
package nfa2d_pkg;

    localparam int NFA_STATES_DEF = 64;
    localparam int DFA_CAP_DEF    = 64;

    localparam int IDX_W      = 6;   // width of a state index field
    localparam int CNT_W      = 7;   // width of a state count
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CMD_W-1:0] CMD_EPS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SYM   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, dropped

    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] dfa_row;
        logic [IDX_W-1:0] next_on_a;
        logic             a_valid;
        logic [IDX_W-1:0] next_on_b;
        logic             b_valid;
        logic             accepting;
        logic             is_start;
        logic             overflow;
        logic             last_row;
    } out_word_t;

endpackage

// ===== src/nfa2d_if.sv =====
// ============================================================================
// nfa2d_if : channel interfaces
// Command channel into the block and result channel out of it.
// ============================================================================
interface nfa2d_in_if;
    import nfa2d_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] from_state;
    logic             symbol;
    logic [IDX_W-1:0] to_state;

    modport source (output valid, command, from_state, symbol, to_state, input ready);
    modport sink   (input valid, command, from_state, symbol, to_state, output ready);
endinterface

interface nfa2d_out_if;
    import nfa2d_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] dfa_row;
    logic [IDX_W-1:0] next_on_a;
    logic             a_valid;
    logic [IDX_W-1:0] next_on_b;
    logic             b_valid;
    logic             accepting;
    logic             is_start;
    logic             overflow;
    logic             last_row;

    modport source (output valid, dfa_row, next_on_a, a_valid, next_on_b, b_valid,
                    accepting, is_start, overflow, last_row, input ready);
    modport sink   (input valid, dfa_row, next_on_a, a_valid, next_on_b, b_valid,
                    accepting, is_start, overflow, last_row, output ready);
endinterface

// ===== src/nfa2d_ram.sv =====
// ============================================================================
// nfa2d_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module nfa2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/nfa2d_out_stage.sv =====
// ============================================================================
// nfa2d_out_stage : result output register
// Holds one result word until the sink takes it.
// ============================================================================
module nfa2d_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  nfa2d_pkg::out_word_t  word,
    output logic                  free,
    nfa2d_out_if.source           out_ch
);
    import nfa2d_pkg::*;

    logic      valid_reg;
    out_word_t word_reg;

    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.dfa_row   = word_reg.dfa_row;
    assign out_ch.next_on_a = word_reg.next_on_a;
    assign out_ch.a_valid   = word_reg.a_valid;
    assign out_ch.next_on_b = word_reg.next_on_b;
    assign out_ch.b_valid   = word_reg.b_valid;
    assign out_ch.accepting = word_reg.accepting;
    assign out_ch.is_start  = word_reg.is_start;
    assign out_ch.overflow  = word_reg.overflow;
    assign out_ch.last_row  = word_reg.last_row;
endmodule

// ===== src/nfa_to_dfa_subset_construction_unit.sv =====
// ============================================================================
// nfa_to_dfa_subset_construction_unit : NFA to DFA subset builder
// Loads an NFA over {a,b}, then builds and streams the DFA table row by row.
// ============================================================================
//
//  channel   dir  handshake     word
//  --------  ---  ------------  -----------------------------------------------
//  in_ch     in   valid/ready   command, from_state, symbol, to_state
//  out_ch    out  valid/ready   one DFA row: targets, flags, last_row
//  cfg       in   cfg_we        cfg_index selects start/accept/count register
//
//  Edge loads: a symbol edge is written on acceptance; an epsilon edge is a
//  read-modify-write of the row memory. Start: init sweep, n closure passes,
//  then per DFA row a load plus, per symbol, move, compare against up to k
//  rows and resolve; each row is then emitted. n: clamped count, k: rows.
//  Reset clears edge valid bits in flops at once; no clearing pass.
//  in_ch is held off during construction and emission; out_ch stalls pause it.
//
module nfa_to_dfa_subset_construction_unit #(
    parameter int NFA_STATES = nfa2d_pkg::NFA_STATES_DEF,
    parameter int DFA_CAP    = nfa2d_pkg::DFA_CAP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nfa2d_in_if.sink                          in_ch,
    nfa2d_out_if.source                       out_ch,
    input  logic                              cfg_we,
    input  logic [nfa2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nfa2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nfa2d_pkg::*;

    localparam int NIW   = $clog2(NFA_STATES);       // NFA index
    localparam int NCW   = $clog2(NFA_STATES + 1);   // NFA count
    localparam int DIW   = $clog2(DFA_CAP);          // DFA index
    localparam int DCW   = $clog2(DFA_CAP + 1);      // DFA count
    localparam int ROW_W = 2 * (DIW + 1);            // {b_vld,b,a_vld,a}

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EPS_WR  = 4'd1;
    localparam logic [3:0] S_INIT    = 4'd2;
    localparam logic [3:0] S_WK_RD   = 4'd3;
    localparam logic [3:0] S_WK_HOLD = 4'd4;
    localparam logic [3:0] S_WK_SW   = 4'd5;
    localparam logic [3:0] S_SEED_RD = 4'd6;
    localparam logic [3:0] S_SEED_WR = 4'd7;
    localparam logic [3:0] S_ROW_RD  = 4'd8;
    localparam logic [3:0] S_ROW_LD  = 4'd9;
    localparam logic [3:0] S_MV      = 4'd10;
    localparam logic [3:0] S_CMP     = 4'd11;
    localparam logic [3:0] S_RES     = 4'd12;
    localparam logic [3:0] S_EM_RD   = 4'd13;
    localparam logic [3:0] S_EM_LD   = 4'd14;

    function automatic logic [NFA_STATES-1:0] onehot(input logic [NIW-1:0] ix);
        logic [NFA_STATES-1:0] v;
        for (int b = 0; b < NFA_STATES; b++)
        begin
            v[b] = (ix == NIW'(b));
        end
        return v;
    endfunction

    // ---- registers ----
    logic [3:0]              state_reg, state_next;
    logic [IDX_W-1:0]        start_reg, accept_reg;
    logic [CNT_W-1:0]        count_cfg_reg;
    logic [NFA_STATES-1:0]   eps_vld_reg, eps_vld_next;
    logic [2*NFA_STATES-1:0] sym_vld_reg, sym_vld_next;
    logic [NCW-1:0]          n_reg, n_next;
    logic [NFA_STATES-1:0]   mask_reg, mask_next;
    logic [NCW-1:0]          c_reg, c_next;
    logic [NCW-1:0]          k_reg, k_next;
    logic                    p1_vld_reg, p1_vld_next;
    logic [NIW-1:0]          p1_addr_reg, p1_addr_next;
    logic                    p2_vld_reg, p2_vld_next;
    logic [DIW-1:0]          pd_addr_reg, pd_addr_next;
    logic [NFA_STATES-1:0]   rk_reg, rk_next;
    logic [NFA_STATES-1:0]   cur_reg, cur_next;
    logic [NFA_STATES-1:0]   acc_reg, acc_next;
    logic [DCW-1:0]          dcount_reg, dcount_next;
    logic [DCW-1:0]          row_reg, row_next;
    logic [DCW-1:0]          j_reg, j_next;
    logic                    found_reg, found_next;
    logic [DIW-1:0]          fidx_reg, fidx_next;
    logic                    sym_reg, sym_next;
    logic [DIW:0]            ta_reg, ta_next;
    logic                    ovf_reg, ovf_next;
    logic                    seed_far_reg, seed_far_next;
    logic [NIW-1:0]          ld_from_reg, ld_from_next;
    logic [NIW-1:0]          ld_to_reg, ld_to_next;

    // ---- memory ports ----
    logic                  eps_we, eps_re;
    logic [NIW-1:0]        eps_waddr, eps_raddr;
    logic [NFA_STATES-1:0] eps_wdata, eps_rd;
    logic                  clos_we, clos_re;
    logic [NIW-1:0]        clos_waddr, clos_raddr;
    logic [NFA_STATES-1:0] clos_wdata, clos_rd;
    logic                  sub_we, sub_re;
    logic [DIW-1:0]        sub_waddr, sub_raddr;
    logic [NFA_STATES-1:0] sub_wdata, sub_rd;
    logic                  dfa_we, dfa_re;
    logic [DIW-1:0]        dfa_waddr, dfa_raddr;
    logic [ROW_W-1:0]      dfa_wdata, dfa_rd;
    logic                  sym_we, sym_re;
    logic [NIW:0]          sym_waddr, sym_raddr;
    logic [NIW-1:0]        sym_rd;

    // ---- combinational helpers ----
    logic                  in_acc, in_range;
    logic [NIW:0]          in_sym_idx, mv_sym_idx;
    logic [CNT_W-1:0]      n_calc;
    logic                  sweep_more, st_in_range;
    logic                  res_vld, res_add, res_ovf;
    logic [DIW-1:0]        res_idx;
    logic                  out_load, out_free;
    out_word_t             out_word;
    logic                  acc_bit, st_bit, em_last;

    nfa2d_ram #(.WIDTH(NFA_STATES), .DEPTH(NFA_STATES)) u_eps_ram (
        .clk(clk), .we(eps_we), .waddr(eps_waddr), .wdata(eps_wdata),
        .re(eps_re), .raddr(eps_raddr), .rdata(eps_rd));

    nfa2d_ram #(.WIDTH(NFA_STATES), .DEPTH(NFA_STATES)) u_clos_ram (
        .clk(clk), .we(clos_we), .waddr(clos_waddr), .wdata(clos_wdata),
        .re(clos_re), .raddr(clos_raddr), .rdata(clos_rd));

    nfa2d_ram #(.WIDTH(NFA_STATES), .DEPTH(DFA_CAP)) u_sub_ram (
        .clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wdata),
        .re(sub_re), .raddr(sub_raddr), .rdata(sub_rd));

    nfa2d_ram #(.WIDTH(ROW_W), .DEPTH(DFA_CAP)) u_dfa_ram (
        .clk(clk), .we(dfa_we), .waddr(dfa_waddr), .wdata(dfa_wdata),
        .re(dfa_re), .raddr(dfa_raddr), .rdata(dfa_rd));

    nfa2d_ram #(.WIDTH(NIW), .DEPTH(2 * NFA_STATES)) u_sym_ram (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(ld_to_next),
        .re(sym_re), .raddr(sym_raddr), .rdata(sym_rd));

    nfa2d_out_stage u_out (
        .clk(clk), .rst_n(rst_n), .load(out_load), .word(out_word),
        .free(out_free), .out_ch(out_ch));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_range    = (CNT_W'(in_ch.from_state) < CNT_W'(NFA_STATES))
                      && (CNT_W'(in_ch.to_state) < CNT_W'(NFA_STATES));
    assign in_sym_idx  = {in_ch.from_state[NIW-1:0], in_ch.symbol};
    assign mv_sym_idx  = {c_reg[NIW-1:0], sym_reg};
    assign st_in_range = CNT_W'(start_reg) < CNT_W'(n_reg);

    // clamp the configured count to 1..NFA_STATES
    always_comb
    begin
        if (count_cfg_reg == '0)
        begin
            n_calc = CNT_W'(1);
        end
        else if (count_cfg_reg > CNT_W'(NFA_STATES))
        begin
            n_calc = CNT_W'(NFA_STATES);
        end
        else
        begin
            n_calc = count_cfg_reg;
        end
    end

    // find_or_add outcome for the set in acc_reg
    always_comb
    begin
        res_vld = 1'b0;
        res_add = 1'b0;
        res_ovf = 1'b0;
        res_idx = '0;
        if (acc_reg == '0)
        begin
            res_vld = 1'b0;
        end
        else if (found_reg)
        begin
            res_vld = 1'b1;
            res_idx = fidx_reg;
        end
        else if (dcount_reg >= DCW'(DFA_CAP))
        begin
            res_ovf = 1'b1;
        end
        else
        begin
            res_vld = 1'b1;
            res_add = 1'b1;
            res_idx = dcount_reg[DIW-1:0];
        end
    end

    // emitted word; the seed may sit outside the set vector (start beyond it)
    assign acc_bit = ((CNT_W'(accept_reg) < CNT_W'(NFA_STATES)) ?
                      sub_rd[accept_reg[NIW-1:0]] : 1'b0)
                   || (row_reg == '0 && seed_far_reg && accept_reg == start_reg);
    assign st_bit  = ((CNT_W'(start_reg) < CNT_W'(NFA_STATES)) ?
                      sub_rd[start_reg[NIW-1:0]] : 1'b0)
                   || (row_reg == '0 && seed_far_reg);
    assign em_last = (row_reg + DCW'(1)) == dcount_reg;

    always_comb
    begin
        out_word.dfa_row   = IDX_W'(row_reg);
        out_word.next_on_a = IDX_W'(dfa_rd[DIW-1:0]);
        out_word.a_valid   = dfa_rd[DIW];
        out_word.next_on_b = IDX_W'(dfa_rd[2*DIW:DIW+1]);
        out_word.b_valid   = dfa_rd[2*DIW+1];
        out_word.accepting = acc_bit;
        out_word.is_start  = st_bit;
        out_word.overflow  = em_last && ovf_reg;
        out_word.last_row  = em_last;
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next    = state_reg;
        eps_vld_next  = eps_vld_reg;
        sym_vld_next  = sym_vld_reg;
        n_next        = n_reg;
        mask_next     = mask_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        p1_vld_next   = p1_vld_reg;
        p1_addr_next  = p1_addr_reg;
        p2_vld_next   = p2_vld_reg;
        pd_addr_next  = pd_addr_reg;
        rk_next       = rk_reg;
        cur_next      = cur_reg;
        acc_next      = acc_reg;
        dcount_next   = dcount_reg;
        row_next      = row_reg;
        j_next        = j_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        sym_next      = sym_reg;
        ta_next       = ta_reg;
        ovf_next      = ovf_reg;
        seed_far_next = seed_far_reg;
        ld_from_next  = ld_from_reg;
        ld_to_next    = in_ch.to_state[NIW-1:0];

        eps_we = 1'b0; eps_waddr = ld_from_reg; eps_wdata = '0;
        eps_re = 1'b0; eps_raddr = in_ch.from_state[NIW-1:0];
        clos_we = 1'b0; clos_waddr = p1_addr_reg; clos_wdata = '0;
        clos_re = 1'b0; clos_raddr = c_reg[NIW-1:0];
        sub_we = 1'b0; sub_waddr = '0; sub_wdata = acc_reg;
        sub_re = 1'b0; sub_raddr = row_reg[DIW-1:0];
        dfa_we = 1'b0; dfa_waddr = row_reg[DIW-1:0];
        dfa_wdata = {res_vld, res_idx, ta_reg};
        dfa_re = 1'b0; dfa_raddr = row_reg[DIW-1:0];
        sym_we = 1'b0; sym_waddr = in_sym_idx;
        sym_re = 1'b0; sym_raddr = mv_sym_idx;
        out_load = 1'b0;
        sweep_more = c_reg < n_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.command)
                        CMD_EPS:
                        begin
                            if (in_range)
                            begin
                                eps_re       = 1'b1;
                                ld_from_next = in_ch.from_state[NIW-1:0];
                                state_next   = S_EPS_WR;
                            end
                        end
                        CMD_SYM:
                        begin
                            // first edge per state and symbol wins
                            if (in_range && !sym_vld_reg[in_sym_idx])
                            begin
                                sym_we                   = 1'b1;
                                sym_vld_next[in_sym_idx] = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            n_next = n_calc[NCW-1:0];
                            for (int b = 0; b < NFA_STATES; b++)
                            begin
                                mask_next[b] = CNT_W'(b) < n_calc;
                            end
                            c_next      = '0;
                            p1_vld_next = 1'b0;
                            ovf_next    = 1'b0;
                            state_next  = S_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_EPS_WR:
            begin
                eps_we    = 1'b1;
                eps_wdata = (eps_vld_reg[ld_from_reg] ? eps_rd : '0) | onehot(ld_to_reg);
                eps_vld_next[ld_from_reg] = 1'b1;
                state_next = S_IDLE;
            end

            // reach[i] = (eps[i] & mask) | {i}
            S_INIT:
            begin
                eps_raddr = c_reg[NIW-1:0];
                if (sweep_more)
                begin
                    eps_re       = 1'b1;
                    p1_vld_next  = 1'b1;
                    p1_addr_next = c_reg[NIW-1:0];
                    c_next       = c_reg + NCW'(1);
                end
                else
                begin
                    p1_vld_next = 1'b0;
                end
                if (p1_vld_reg)
                begin
                    clos_we    = 1'b1;
                    clos_wdata = (eps_vld_reg[p1_addr_reg] ? (eps_rd & mask_reg) : '0)
                               | onehot(p1_addr_reg);
                end
                if (!sweep_more && !p1_vld_reg)
                begin
                    k_next     = '0;
                    state_next = S_WK_RD;
                end
            end

            // transitive closure, one pivot k per pass
            S_WK_RD:
            begin
                clos_re    = 1'b1;
                clos_raddr = k_reg[NIW-1:0];
                state_next = S_WK_HOLD;
            end

            S_WK_HOLD:
            begin
                rk_next     = clos_rd;
                c_next      = '0;
                p1_vld_next = 1'b0;
                state_next  = S_WK_SW;
            end

            S_WK_SW:
            begin
                if (sweep_more)
                begin
                    clos_re      = 1'b1;
                    p1_vld_next  = 1'b1;
                    p1_addr_next = c_reg[NIW-1:0];
                    c_next       = c_reg + NCW'(1);
                end
                else
                begin
                    p1_vld_next = 1'b0;
                end
                if (p1_vld_reg && clos_rd[k_reg[NIW-1:0]])
                begin
                    clos_we    = 1'b1;
                    clos_wdata = clos_rd | rk_reg;
                end
                if (!sweep_more && !p1_vld_reg)
                begin
                    if (k_reg + NCW'(1) == n_reg)
                    begin
                        state_next = S_SEED_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + NCW'(1);
                        state_next = S_WK_RD;
                    end
                end
            end

            S_SEED_RD:
            begin
                clos_re    = 1'b1;
                clos_raddr = start_reg[NIW-1:0];
                state_next = S_SEED_WR;
            end

            S_SEED_WR:
            begin
                sub_we    = 1'b1;
                sub_waddr = '0;
                if (st_in_range)
                begin
                    sub_wdata = clos_rd;
                end
                else if (CNT_W'(start_reg) < CNT_W'(NFA_STATES))
                begin
                    sub_wdata = onehot(start_reg[NIW-1:0]);
                end
                else
                begin
                    sub_wdata = '0;
                end
                seed_far_next = !(CNT_W'(start_reg) < CNT_W'(NFA_STATES));
                dcount_next   = DCW'(1);
                row_next      = '0;
                state_next    = S_ROW_RD;
            end

            S_ROW_RD:
            begin
                sub_re     = 1'b1;
                state_next = S_ROW_LD;
            end

            S_ROW_LD:
            begin
                cur_next    = sub_rd;
                sym_next    = 1'b0;
                c_next      = '0;
                p1_vld_next = 1'b0;
                p2_vld_next = 1'b0;
                acc_next    = '0;
                state_next  = S_MV;
            end

            // move set: member -> symbol target -> closure, three stages
            S_MV:
            begin
                if (sweep_more)
                begin
                    sym_re       = 1'b1;
                    p1_vld_next  = cur_reg[c_reg[NIW-1:0]] && sym_vld_reg[mv_sym_idx];
                    c_next       = c_reg + NCW'(1);
                end
                else
                begin
                    p1_vld_next = 1'b0;
                end
                clos_raddr  = sym_rd;
                p2_vld_next = p1_vld_reg && (NCW'(sym_rd) < n_reg);
                if (p2_vld_next)
                begin
                    clos_re = 1'b1;
                end
                if (p2_vld_reg)
                begin
                    acc_next = acc_reg | clos_rd;
                end
                if (!sweep_more && !p1_vld_reg && !p2_vld_reg)
                begin
                    j_next      = '0;
                    found_next  = 1'b0;
                    p1_vld_next = 1'b0;
                    state_next  = S_CMP;
                end
            end

            // search known subsets
            S_CMP:
            begin
                sub_raddr = j_reg[DIW-1:0];
                if (j_reg < dcount_reg && acc_reg != '0)
                begin
                    sub_re       = 1'b1;
                    p1_vld_next  = 1'b1;
                    pd_addr_next = j_reg[DIW-1:0];
                    j_next       = j_reg + DCW'(1);
                end
                else
                begin
                    p1_vld_next = 1'b0;
                end
                if (p1_vld_reg && sub_rd == acc_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = pd_addr_reg;
                end
                if (!(j_reg < dcount_reg && acc_reg != '0) && !p1_vld_reg)
                begin
                    state_next = S_RES;
                end
            end

            S_RES:
            begin
                if (res_add)
                begin
                    sub_we      = 1'b1;
                    sub_waddr   = dcount_reg[DIW-1:0];
                    dcount_next = dcount_reg + DCW'(1);
                end
                if (res_ovf)
                begin
                    ovf_next = 1'b1;
                end
                if (!sym_reg)
                begin
                    ta_next     = {res_vld, res_idx};
                    sym_next    = 1'b1;
                    c_next      = '0;
                    acc_next    = '0;
                    p1_vld_next = 1'b0;
                    p2_vld_next = 1'b0;
                    state_next  = S_MV;
                end
                else
                begin
                    dfa_we = 1'b1;
                    if (row_reg + DCW'(1) < dcount_next)
                    begin
                        row_next   = row_reg + DCW'(1);
                        state_next = S_ROW_RD;
                    end
                    else
                    begin
                        row_next   = '0;
                        state_next = S_EM_RD;
                    end
                end
            end

            S_EM_RD:
            begin
                if (out_free)
                begin
                    sub_re     = 1'b1;
                    dfa_re     = 1'b1;
                    state_next = S_EM_LD;
                end
            end

            S_EM_LD:
            begin
                out_load = 1'b1;
                row_next = row_reg + DCW'(1);
                if (em_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EM_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---- configuration and control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            accept_reg    <= '0;
            count_cfg_reg <= CNT_W'(1);
            state_reg     <= S_IDLE;
            eps_vld_reg   <= '0;
            sym_vld_reg   <= '0;
            n_reg         <= NCW'(1);
            c_reg         <= '0;
            k_reg         <= '0;
            p1_vld_reg    <= 1'b0;
            p1_addr_reg   <= '0;
            p2_vld_reg    <= 1'b0;
            pd_addr_reg   <= '0;
            dcount_reg    <= '0;
            row_reg       <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            fidx_reg      <= '0;
            sym_reg       <= 1'b0;
            ta_reg        <= '0;
            ovf_reg       <= 1'b0;
            seed_far_reg  <= 1'b0;
            ld_from_reg   <= '0;
            ld_to_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START:  start_reg     <= cfg_data[IDX_W-1:0];
                    REG_ACCEPT: accept_reg    <= cfg_data[IDX_W-1:0];
                    REG_COUNT:  count_cfg_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg    <= state_next;
            eps_vld_reg  <= eps_vld_next;
            sym_vld_reg  <= sym_vld_next;
            n_reg        <= n_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            p1_vld_reg   <= p1_vld_next;
            p1_addr_reg  <= p1_addr_next;
            p2_vld_reg   <= p2_vld_next;
            pd_addr_reg  <= pd_addr_next;
            dcount_reg   <= dcount_next;
            row_reg      <= row_next;
            j_reg        <= j_next;
            found_reg    <= found_next;
            fidx_reg     <= fidx_next;
            sym_reg      <= sym_next;
            ta_reg       <= ta_next;
            ovf_reg      <= ovf_next;
            seed_far_reg <= seed_far_next;
            ld_from_reg  <= ld_from_next;
            if (in_acc)
            begin
                ld_to_reg <= ld_to_next;
            end
        end
    end

    // ---- wide working sets ----
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        rk_reg   <= rk_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
    end

endmodule
